@@ sv/ifrq_pkg.sv @@
package ifrq_pkg;

    localparam int IMAGE_BYTES_DEF = 784;

    localparam int BYTE_W   = 8;
    localparam int GAIN_W   = 24;
    localparam int COUNT_W  = 32;
    localparam int SEQ_W    = 32;
    localparam int INDEX_W  = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [31:0] SYNC_WORD = 32'h4B4D_4E31;
    localparam logic [3:0]  HEADER_LAST = 4'd7;

    localparam logic                quantize_on_RST = 1'b1;
    localparam logic [GAIN_W-1:0]   PIXEL_GAIN_RST  = 24'd65536;
    localparam logic signed [7:0]   ZERO_OFFSET_RST = -8'sd128;

    localparam logic signed [17:0]  PIX_MIN = -18'sd128;
    localparam logic signed [17:0]  PIX_MAX = 18'sd127;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUANTIZE_ON = 2'd0,
        CFG_PIXEL_GAIN  = 2'd1,
        CFG_ZERO_OFFSET = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_DISCARD = 4'b1000
    } phase_t;

endpackage

@@ sv/image_frame_receiver_quantizer_unit.sv @@
// Frame receiver and pixel quantizer.
// Input channel (in_valid/in_ready, rx_byte): one received byte per item.
// The block hunts for the sync word "KMN1", then reads a little-endian
// sequence number and length. A length other than IMAGE_BYTES is skipped
// byte by byte; a matching frame yields one result per payload byte.
// Output channel (out_valid/out_ready): frame_seq, pixel_value (int8
// quantized, or raw bits when quantize_on is 0), pixel_index, last_pixel.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
// write only while no item is in flight. Unused indexes are ignored.
// A received byte passes through the input register, then the result register;
// the result register loads when the input register advances. Throughput:
// one byte per cycle while the output is not stalled, set by the
// combinational 8x24 multiply and the phase update.
// Reset puts the block in the hunt phase with empty window and counters
// and loads the register defaults; no results are pending.
// When the receiver stalls, the result register holds, the input register holds
// at most one byte, and in_ready stays low while it is full.
module image_frame_receiver_quantizer_unit
#(
    parameter int IMAGE_BYTES = ifrq_pkg::IMAGE_BYTES_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [ifrq_pkg::BYTE_W-1:0]      rx_byte,

    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ifrq_pkg::SEQ_W-1:0]       frame_seq,
    output logic signed [7:0]                pixel_value,
    output logic [ifrq_pkg::INDEX_W-1:0]     pixel_index,
    output logic                             last_pixel,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ifrq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ifrq_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [ifrq_pkg::COUNT_W-1:0] IMAGE_LEN  = ifrq_pkg::COUNT_W'(IMAGE_BYTES);
    localparam logic [ifrq_pkg::INDEX_W-1:0] LAST_INDEX = ifrq_pkg::INDEX_W'(IMAGE_BYTES - 1);

    logic                                quantize_on_reg;
    logic [ifrq_pkg::GAIN_W-1:0]         pixel_gain_reg;
    logic signed [7:0]                   zero_offset_reg;

    logic                                s1_valid_reg;
    logic [ifrq_pkg::BYTE_W-1:0]         s1_byte_reg;

    ifrq_pkg::phase_t                    phase_reg, phase_next;
    logic [23:0]                         window_reg, window_next;
    logic [ifrq_pkg::COUNT_W-1:0]        count_reg, count_next;
    logic [ifrq_pkg::SEQ_W-1:0]          seq_reg, seq_next;
    logic [ifrq_pkg::COUNT_W-1:0]        length_reg, length_next;

    logic                                out_valid_reg;
    logic [ifrq_pkg::SEQ_W-1:0]          frame_seq_reg;
    logic [7:0]                          pixel_value_reg;
    logic [ifrq_pkg::INDEX_W-1:0]        pixel_index_reg;
    logic                                last_pixel_reg;

    logic                                advance;
    logic                                emit;
    logic                                is_last;
    logic [ifrq_pkg::COUNT_W-1:0]        count_inc;
    logic [31:0]                         full_length;
    logic [4:0]                          byte_shift;
    logic [7:0]                          quant_value;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantize_on_reg <= ifrq_pkg::quantize_on_RST;
            pixel_gain_reg  <= ifrq_pkg::PIXEL_GAIN_RST;
            zero_offset_reg <= ifrq_pkg::ZERO_OFFSET_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (ifrq_pkg::cfg_index_t'(cfg_index))
                ifrq_pkg::CFG_QUANTIZE_ON: quantize_on_reg <= cfg_data[0];
                ifrq_pkg::CFG_PIXEL_GAIN:  pixel_gain_reg  <= cfg_data[ifrq_pkg::GAIN_W-1:0];
                ifrq_pkg::CFG_ZERO_OFFSET: zero_offset_reg <= $signed(cfg_data[7:0]);
                default:                   ;
            endcase
        end
    end

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    ifrq_quant u_quant
    (
        .pixel_byte  (s1_byte_reg),
        .quantize_on (quantize_on_reg),
        .pixel_gain  (pixel_gain_reg),
        .zero_offset (zero_offset_reg),
        .pixel_value (quant_value)
    );

    always_comb
    begin
        phase_next  = phase_reg;
        window_next = window_reg;
        count_next  = count_reg;
        seq_next    = seq_reg;
        length_next = length_reg;
        emit        = 1'b0;
        count_inc   = count_reg + 32'd1;
        is_last     = (count_inc == IMAGE_LEN);
        byte_shift  = {count_reg[1:0], 3'b000};
        full_length = {s1_byte_reg, length_reg[23:0]};

        unique case (phase_reg)
            ifrq_pkg::PH_HUNT:
            begin
                if ({window_reg, s1_byte_reg} == ifrq_pkg::SYNC_WORD)
                begin
                    phase_next  = ifrq_pkg::PH_HEADER;
                    count_next  = '0;
                    seq_next    = '0;
                    length_next = '0;
                end
                else
                begin
                    window_next = {window_reg[15:0], s1_byte_reg};
                end
            end
            ifrq_pkg::PH_HEADER:
            begin
                if (!count_reg[2])
                begin
                    seq_next = seq_reg | (32'(s1_byte_reg) << byte_shift);
                end
                else
                begin
                    length_next = length_reg | (32'(s1_byte_reg) << byte_shift);
                end
                count_next = count_inc;
                if (count_reg[3:0] == ifrq_pkg::HEADER_LAST)
                begin
                    count_next = '0;
                    if (full_length == IMAGE_LEN)
                    begin
                        phase_next = ifrq_pkg::PH_PAYLOAD;
                    end
                    else if (full_length == 32'd0)
                    begin
                        phase_next  = ifrq_pkg::PH_HUNT;
                        window_next = '0;
                    end
                    else
                    begin
                        phase_next = ifrq_pkg::PH_DISCARD;
                    end
                end
            end
            ifrq_pkg::PH_DISCARD:
            begin
                count_next = count_inc;
                if (count_inc >= length_reg)
                begin
                    phase_next  = ifrq_pkg::PH_HUNT;
                    window_next = '0;
                    count_next  = '0;
                end
            end
            ifrq_pkg::PH_PAYLOAD:
            begin
                emit       = 1'b1;
                count_next = count_inc;
                if (is_last)
                begin
                    phase_next  = ifrq_pkg::PH_HUNT;
                    window_next = '0;
                    count_next  = '0;
                end
            end
            default:
            begin
                phase_next  = ifrq_pkg::PH_HUNT;
                window_next = '0;
                count_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= ifrq_pkg::PH_HUNT;
            window_reg <= '0;
            count_reg  <= '0;
            seq_reg    <= '0;
            length_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            window_reg <= window_next;
            count_reg  <= count_next;
            seq_reg    <= seq_next;
            length_reg <= length_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            frame_seq_reg   <= seq_reg;
            pixel_value_reg <= quant_value;
            pixel_index_reg <= count_reg[ifrq_pkg::INDEX_W-1:0];
            last_pixel_reg  <= is_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_seq   = frame_seq_reg;
    assign pixel_value = $signed(pixel_value_reg);
    assign pixel_index = pixel_index_reg;
    assign last_pixel  = last_pixel_reg;

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == ifrq_pkg::PH_PAYLOAD |-> count_reg < IMAGE_LEN)
        else $error("payload count beyond frame size");

    a_header_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == ifrq_pkg::PH_HEADER |-> count_reg < 32'd8)
        else $error("header count beyond eight bytes");

    a_discard_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == ifrq_pkg::PH_DISCARD |-> count_reg < length_reg)
        else $error("discard count beyond frame length");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_pixel_reg |-> pixel_index_reg == LAST_INDEX)
        else $error("last pixel at wrong index");

    a_last_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit && is_last |=> phase_reg == ifrq_pkg::PH_HUNT && window_reg == 24'd0)
        else $error("no new hunt after last pixel");

endmodule

@@ sv/ifrq_quant.sv @@
module ifrq_quant
(
    input  logic [ifrq_pkg::BYTE_W-1:0] pixel_byte,
    input  logic                        quantize_on,
    input  logic [ifrq_pkg::GAIN_W-1:0] pixel_gain,
    input  logic signed [7:0]           zero_offset,
    output logic [7:0]                  pixel_value
);

    logic [31:0]        product;
    logic [15:0]        whole;
    logic [15:0]        frac;
    logic               round_up;
    logic [16:0]        rounded;
    logic signed [17:0] biased;
    logic [7:0]         quantized;

    always_comb
    begin
        product  = 32'(pixel_byte) * 32'(pixel_gain);
        whole    = product[31:16];
        frac     = product[15:0];
        round_up = (frac > 16'h8000) || ((frac == 16'h8000) && whole[0]);
        rounded  = 17'(whole) + 17'(round_up);
        biased   = $signed({1'b0, rounded}) + 18'(zero_offset);
        if (biased < ifrq_pkg::PIX_MIN)
        begin
            quantized = 8'h80;
        end
        else if (biased > ifrq_pkg::PIX_MAX)
        begin
            quantized = 8'h7F;
        end
        else
        begin
            quantized = biased[7:0];
        end
        pixel_value = quantize_on ? quantized : pixel_byte;
    end

endmodule

@@ sim/image_frame_receiver_quantizer_unit_tb.sv @@
`timescale 1ns / 1ps

module image_frame_receiver_quantizer_unit_tb;

    localparam int FRAME_BYTES = ifrq_pkg::IMAGE_BYTES_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT = 2000;
    localparam int GOOD_PHASE = 4;
    localparam int SEQS_PER_PHASE = 4;
    localparam logic [ifrq_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [ifrq_pkg::SEQ_W-1:0]   seq;
        logic signed [7:0]            value;
        logic [ifrq_pkg::INDEX_W-1:0] index;
        logic                         last;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                              in_valid = 1'b0;
    logic                              in_ready;
    logic [ifrq_pkg::BYTE_W-1:0]       rx_byte = '0;

    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic [ifrq_pkg::SEQ_W-1:0]        frame_seq;
    logic signed [7:0]                 pixel_value;
    logic [ifrq_pkg::INDEX_W-1:0]      pixel_index;
    logic                              last_pixel;

    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [ifrq_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [ifrq_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

    logic [ifrq_pkg::BYTE_W-1:0] rx_pending[$];
    pixel_t            pixels_due[$];
    pixel_t            due_px;
    int                err_count = 0;
    int                quiet_cycles = 0;
    int                send_gap_pct = 15;
    int                stall_pct = 15;

    // receiver copy
    logic                          quant_en_r = 1'b1;
    logic [ifrq_pkg::GAIN_W-1:0]   gain_r = ifrq_pkg::PIXEL_GAIN_RST;
    logic signed [7:0]             zoff_r = ifrq_pkg::ZERO_OFFSET_RST;
    ifrq_pkg::phase_t              rx_state = ifrq_pkg::PH_HUNT;
    logic [23:0]                   win_r = '0;
    logic [31:0]                   cnt_r = '0;
    logic [31:0]                   seq_r = '0;
    logic [31:0]                   len_r = '0;

    image_frame_receiver_quantizer_unit #(
        .IMAGE_BYTES(FRAME_BYTES)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .frame_seq(frame_seq),
        .pixel_value(pixel_value),
        .pixel_index(pixel_index),
        .last_pixel(last_pixel),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic signed [7:0] quantize(logic [7:0] b);
        logic [31:0]        prod;
        logic [16:0]        whole;
        logic signed [18:0] sum;
        prod = b * gain_r;
        whole = {1'b0, prod[31:16]};
        if (prod[15:0] > 16'h8000 || (prod[15:0] == 16'h8000 && prod[16]))
            whole = whole + 17'd1;
        sum = $signed({2'b00, whole}) + zoff_r;
        if (sum < ifrq_pkg::PIX_MIN)
            sum = ifrq_pkg::PIX_MIN;
        if (sum > ifrq_pkg::PIX_MAX)
            sum = ifrq_pkg::PIX_MAX;
        return sum[7:0];
    endfunction

    function automatic void restart_hunt();
        rx_state = ifrq_pkg::PH_HUNT;
        win_r = '0;
        cnt_r = '0;
    endfunction

    function automatic void receive_byte(logic [7:0] b);
        pixel_t px;
        case (rx_state)
            ifrq_pkg::PH_HUNT:
            begin
                if ({win_r, b} == ifrq_pkg::SYNC_WORD)
                begin
                    rx_state = ifrq_pkg::PH_HEADER;
                    cnt_r = '0;
                    seq_r = '0;
                    len_r = '0;
                end
                else
                    win_r = {win_r[15:0], b};
            end
            ifrq_pkg::PH_HEADER:
            begin
                if (cnt_r < 4)
                    seq_r[8*cnt_r[1:0] +: 8] = b;
                else
                    len_r[8*cnt_r[1:0] +: 8] = b;
                cnt_r = cnt_r + 1;
                if (cnt_r >= 8)
                begin
                    cnt_r = '0;
                    if (len_r == FRAME_BYTES)
                        rx_state = ifrq_pkg::PH_PAYLOAD;
                    else if (len_r == 0)
                        restart_hunt();
                    else
                        rx_state = ifrq_pkg::PH_DISCARD;
                end
            end
            ifrq_pkg::PH_DISCARD:
            begin
                cnt_r = cnt_r + 1;
                if (cnt_r >= len_r)
                    restart_hunt();
            end
            ifrq_pkg::PH_PAYLOAD:
            begin
                px.seq = seq_r;
                px.value = quant_en_r ? quantize(b) : b;
                px.index = cnt_r[ifrq_pkg::INDEX_W-1:0];
                px.last = (cnt_r + 32'd1) >= FRAME_BYTES;
                pixels_due.push_back(px);
                if (px.last)
                    restart_hunt();
                else
                    cnt_r = cnt_r + 1;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void note_error(string msg);
        err_count++;
        if (err_count <= 10)
            $display("%s", msg);
    endfunction

    function automatic void push_word(logic [31:0] w);
        for (int i = 0; i < 4; i++)
            rx_pending.push_back(w[8*i +: 8]);
    endfunction

    function automatic void push_header(logic [31:0] seq, logic [31:0] len);
        for (int i = 3; i >= 0; i--)
            rx_pending.push_back(ifrq_pkg::SYNC_WORD[8*i +: 8]);
        push_word(seq);
        push_word(len);
    endfunction

    function automatic void push_good_frame();
        push_header($urandom, FRAME_BYTES);
        repeat (FRAME_BYTES)
            rx_pending.push_back(8'($urandom));
    endfunction

    // broken frames, empty frames, partial sync words and line noise
    function automatic void push_random_sequence();
        int kind;
        int len;
        kind = $urandom_range(0, 99);
        if (kind < 45)
        begin
            len = $urandom_range(1, 48);
            push_header($urandom, len);
            repeat (len)
                rx_pending.push_back(8'($urandom));
        end
        else if (kind < 60)
            push_header($urandom, 0);
        else if (kind < 80)
        begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
                rx_pending.push_back(ifrq_pkg::SYNC_WORD[31-8*i -: 8]);
            rx_pending.push_back(8'h00);
        end
        else
            repeat ($urandom_range(1, 12))
                rx_pending.push_back(8'($urandom));
    endfunction

    task automatic write_reg(logic [ifrq_pkg::CFG_IDX_W-1:0] idx,
                             logic [ifrq_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (rx_pending.size() != 0 || in_valid || pixels_due.size() != 0);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (rx_pending.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
            begin
                in_valid <= 1'b1;
                rx_byte <= rx_pending.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ifrq_pkg::CFG_QUANTIZE_ON: quant_en_r = cfg_data[0];
                    ifrq_pkg::CFG_PIXEL_GAIN:  gain_r = cfg_data[ifrq_pkg::GAIN_W-1:0];
                    ifrq_pkg::CFG_ZERO_OFFSET: zoff_r = cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && in_ready)
                receive_byte(rx_byte);
            if (out_valid && out_ready)
            begin
                if (pixels_due.size() == 0)
                    note_error($sformatf("unexpected pixel: seq=%h value=%0d index=%0d last=%b",
                        frame_seq, pixel_value, pixel_index, last_pixel));
                else
                begin
                    due_px = pixels_due.pop_front();
                    if (frame_seq !== due_px.seq || pixel_value !== due_px.value ||
                        pixel_index !== due_px.index || last_pixel !== due_px.last)
                        note_error($sformatf({"pixel mismatch: expected seq=%h value=%0d ",
                            "index=%0d last=%b, got seq=%h value=%0d index=%0d last=%b"},
                            due_px.seq, due_px.value, due_px.index, due_px.last,
                            frame_seq, pixel_value, pixel_index, last_pixel));
                end
            end
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int good_slot;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;

        // overlapping sync start, empty frame, stale window after a new hunt,
        // one-byte discard
        rx_pending.push_back(ifrq_pkg::SYNC_WORD[31:24]);
        push_header(32'hFFFF_FFFF, 32'd0);
        rx_pending.push_back(ifrq_pkg::SYNC_WORD[7:0]);
        push_header(32'h0000_0000, 32'd1);
        rx_pending.push_back(8'hFF);

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                1:
                begin
                    write_reg(ifrq_pkg::CFG_QUANTIZE_ON, 32'd1);
                    write_reg(ifrq_pkg::CFG_PIXEL_GAIN, 32'h00FF_FFFF);
                    write_reg(ifrq_pkg::CFG_ZERO_OFFSET, 32'h0000_007F);
                    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
                end
                2:
                begin
                    write_reg(ifrq_pkg::CFG_QUANTIZE_ON, 32'd0);
                    write_reg(ifrq_pkg::CFG_PIXEL_GAIN, 32'd0);
                    write_reg(ifrq_pkg::CFG_ZERO_OFFSET, 32'h0000_0080);
                    send_gap_pct = 0;
                    stall_pct = 0;
                end
                3:
                begin
                    // odd multiples of one half give exact ties on odd bytes
                    write_reg(ifrq_pkg::CFG_QUANTIZE_ON, 32'd1);
                    write_reg(ifrq_pkg::CFG_PIXEL_GAIN, (2 * $urandom_range(0, 1) + 1) << 15);
                    write_reg(ifrq_pkg::CFG_ZERO_OFFSET, $urandom_range(0, 255));
                    send_gap_pct = 15;
                    stall_pct = 15;
                end
                4:
                begin
                    // odd multiples of one quarter give fractions below, at and above one half
                    write_reg(ifrq_pkg::CFG_PIXEL_GAIN, (2 * $urandom_range(0, 15) + 1) << 14);
                    write_reg(ifrq_pkg::CFG_ZERO_OFFSET, $urandom_range(0, 255));
                end
                default:
                begin
                end
            endcase
            if (ph > 0)
                cfg_valid <= 1'b0;

            good_slot = $urandom_range(0, SEQS_PER_PHASE - 1);
            for (int s = 0; s < SEQS_PER_PHASE; s++)
            begin
                if (ph == GOOD_PHASE && s == good_slot)
                    push_good_frame();
                push_random_sequence();
            end
            // overlong length swallows everything after it
            if (ph == 4)
            begin
                push_header($urandom, 32'hFFFF_FFFF);
                push_header($urandom, FRAME_BYTES);
                repeat (16)
                    rx_pending.push_back(8'($urandom));
            end
            wait_drained();
        end

        if (err_count == 0 && pixels_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
sv/ifrq_pkg.sv
sv/ifrq_quant.sv
sv/image_frame_receiver_quantizer_unit.sv
sim/image_frame_receiver_quantizer_unit_tb.sv
